FILE: sv/nrth_pkg.sv
// Shared types, register codes and the microprogram for the nearest-hit core.
// Used by nrth_ctrl, nrth_dp and nearest_ray_triangle_hit_core; no dependencies.
package nrth_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int W               = 128;  // internal two's complement word
    localparam int AW              = 6;    // scratch memory address width
    localparam int PCW             = 7;
    localparam int LOAD_CNT        = 16;   // slots filled before the program runs
    localparam int DIST_W          = 31;

    localparam logic [PCW-1:0] PC_LAST = 7'd75;

    // configuration register indexes
    localparam logic [2:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] CFG_ORIGIN_Z = 3'd2;
    localparam logic [2:0] CFG_DIR_X    = 3'd3;
    localparam logic [2:0] CFG_DIR_Y    = 3'd4;
    localparam logic [2:0] CFG_DIR_Z    = 3'd5;
    localparam logic [2:0] CFG_EPSILON  = 3'd6;
    localparam logic [2:0] CFG_MAX_DIST = 3'd7;

    // scratch slots; 0..15 are filled in order by the load phase
    localparam logic [AW-1:0] S_AX = 6'd0,  S_AY = 6'd1,  S_AZ = 6'd2;
    localparam logic [AW-1:0] S_BX = 6'd3,  S_BY = 6'd4,  S_BZ = 6'd5;
    localparam logic [AW-1:0] S_CX = 6'd6,  S_CY = 6'd7,  S_CZ = 6'd8;
    localparam logic [AW-1:0] S_OX = 6'd9,  S_OY = 6'd10, S_OZ = 6'd11;
    localparam logic [AW-1:0] S_DX = 6'd12, S_DY = 6'd13, S_DZ = 6'd14;
    localparam logic [AW-1:0] S_EPS = 6'd15;
    localparam logic [AW-1:0] S_E1X = 6'd16, S_E1Y = 6'd17, S_E1Z = 6'd18;
    localparam logic [AW-1:0] S_E2X = 6'd19, S_E2Y = 6'd20, S_E2Z = 6'd21;
    localparam logic [AW-1:0] S_PX = 6'd22,  S_PY = 6'd23,  S_PZ = 6'd24;
    localparam logic [AW-1:0] S_SX = 6'd25,  S_SY = 6'd26,  S_SZ = 6'd27;
    localparam logic [AW-1:0] S_QX = 6'd28,  S_QY = 6'd29,  S_QZ = 6'd30;
    localparam logic [AW-1:0] S_T1 = 6'd31,  S_T2 = 6'd32,  S_DET = 6'd33;
    localparam logic [AW-1:0] S_DABS = 6'd34, S_UN = 6'd35, S_VN = 6'd36;
    localparam logic [AW-1:0] S_TN = 6'd37,  S_TQ = 6'd38,  S_T3 = 6'd39;

    typedef enum logic [4:0] {
        OP_SUB, OP_ADD, OP_MUL, OP_ABS, OP_NEGIF, OP_SHL2F, OP_SHLF, OP_SARF,
        OP_DIV, OP_REJ_ZLTU, OP_REJ_NEG, OP_REJ_LTS, OP_REJ_NLTS, OP_REJ_LIM,
        OP_BESTX, OP_BESTY, OP_BESTZ, OP_BESTD
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE, ST_LOAD, ST_READ, ST_EXEC, ST_WAIT, ST_FINISH
    } t_state;

    typedef struct packed {
        t_op           op;
        logic [AW-1:0] dst;
        logic [AW-1:0] a;
        logic [AW-1:0] b;
    } t_instr;

    typedef struct packed {
        logic          capture;
        logic          load;
        logic [3:0]    load_sel;
        logic          exec;
        t_op           op;
        logic [AW-1:0] dst;
        logic [AW-1:0] ra;
        logic [AW-1:0] rb;
        logic          emit;
    } t_cmd;

    typedef struct packed {
        logic reject;
        logic unit_done;
        logic last;
        logic out_free;
    } t_status;

    function automatic logic is_multi(input t_op op);
        return (op == OP_MUL) || (op == OP_DIV);
    endfunction

    function automatic t_instr mk(input t_op op, input logic [AW-1:0] d,
                                  input logic [AW-1:0] a, input logic [AW-1:0] b);
        t_instr r;
        r.op = op; r.dst = d; r.a = a; r.b = b;
        return r;
    endfunction

    function automatic t_instr prog(input logic [PCW-1:0] pc);
        t_instr r;
        case (pc)
            7'd0:  r = mk(OP_SUB, S_E1X, S_BX, S_AX);
            7'd1:  r = mk(OP_SUB, S_E1Y, S_BY, S_AY);
            7'd2:  r = mk(OP_SUB, S_E1Z, S_BZ, S_AZ);
            7'd3:  r = mk(OP_SUB, S_E2X, S_CX, S_AX);
            7'd4:  r = mk(OP_SUB, S_E2Y, S_CY, S_AY);
            7'd5:  r = mk(OP_SUB, S_E2Z, S_CZ, S_AZ);
            7'd6:  r = mk(OP_MUL, S_T1, S_DY, S_E2Z);
            7'd7:  r = mk(OP_MUL, S_T2, S_DZ, S_E2Y);
            7'd8:  r = mk(OP_SUB, S_PX, S_T1, S_T2);
            7'd9:  r = mk(OP_MUL, S_T1, S_DZ, S_E2X);
            7'd10: r = mk(OP_MUL, S_T2, S_DX, S_E2Z);
            7'd11: r = mk(OP_SUB, S_PY, S_T1, S_T2);
            7'd12: r = mk(OP_MUL, S_T1, S_DX, S_E2Y);
            7'd13: r = mk(OP_MUL, S_T2, S_DY, S_E2X);
            7'd14: r = mk(OP_SUB, S_PZ, S_T1, S_T2);
            7'd15: r = mk(OP_MUL, S_T1, S_E1X, S_PX);
            7'd16: r = mk(OP_MUL, S_T2, S_E1Y, S_PY);
            7'd17: r = mk(OP_ADD, S_T1, S_T1, S_T2);
            7'd18: r = mk(OP_MUL, S_T2, S_E1Z, S_PZ);
            7'd19: r = mk(OP_ADD, S_DET, S_T1, S_T2);
            7'd20: r = mk(OP_ABS, S_DABS, S_DET, S_DET);
            7'd21: r = mk(OP_SHL2F, S_T3, S_EPS, S_EPS);
            7'd22: r = mk(OP_REJ_ZLTU, S_T3, S_DABS, S_T3);
            7'd23: r = mk(OP_SUB, S_SX, S_OX, S_AX);
            7'd24: r = mk(OP_SUB, S_SY, S_OY, S_AY);
            7'd25: r = mk(OP_SUB, S_SZ, S_OZ, S_AZ);
            7'd26: r = mk(OP_MUL, S_T1, S_SX, S_PX);
            7'd27: r = mk(OP_MUL, S_T2, S_SY, S_PY);
            7'd28: r = mk(OP_ADD, S_T1, S_T1, S_T2);
            7'd29: r = mk(OP_MUL, S_T2, S_SZ, S_PZ);
            7'd30: r = mk(OP_ADD, S_T1, S_T1, S_T2);
            7'd31: r = mk(OP_NEGIF, S_UN, S_T1, S_T1);
            7'd32: r = mk(OP_REJ_NEG, S_T3, S_UN, S_UN);
            7'd33: r = mk(OP_REJ_LTS, S_T3, S_DABS, S_UN);
            7'd34: r = mk(OP_MUL, S_T1, S_SY, S_E1Z);
            7'd35: r = mk(OP_MUL, S_T2, S_SZ, S_E1Y);
            7'd36: r = mk(OP_SUB, S_QX, S_T1, S_T2);
            7'd37: r = mk(OP_MUL, S_T1, S_SZ, S_E1X);
            7'd38: r = mk(OP_MUL, S_T2, S_SX, S_E1Z);
            7'd39: r = mk(OP_SUB, S_QY, S_T1, S_T2);
            7'd40: r = mk(OP_MUL, S_T1, S_SX, S_E1Y);
            7'd41: r = mk(OP_MUL, S_T2, S_SY, S_E1X);
            7'd42: r = mk(OP_SUB, S_QZ, S_T1, S_T2);
            7'd43: r = mk(OP_MUL, S_T1, S_DX, S_QX);
            7'd44: r = mk(OP_MUL, S_T2, S_DY, S_QY);
            7'd45: r = mk(OP_ADD, S_T1, S_T1, S_T2);
            7'd46: r = mk(OP_MUL, S_T2, S_DZ, S_QZ);
            7'd47: r = mk(OP_ADD, S_T1, S_T1, S_T2);
            7'd48: r = mk(OP_NEGIF, S_VN, S_T1, S_T1);
            7'd49: r = mk(OP_REJ_NEG, S_T3, S_VN, S_VN);
            7'd50: r = mk(OP_ADD, S_T3, S_UN, S_VN);
            7'd51: r = mk(OP_REJ_LTS, S_T3, S_DABS, S_T3);
            7'd52: r = mk(OP_MUL, S_T1, S_E2X, S_QX);
            7'd53: r = mk(OP_MUL, S_T2, S_E2Y, S_QY);
            7'd54: r = mk(OP_ADD, S_T1, S_T1, S_T2);
            7'd55: r = mk(OP_MUL, S_T2, S_E2Z, S_QZ);
            7'd56: r = mk(OP_ADD, S_T1, S_T1, S_T2);
            7'd57: r = mk(OP_NEGIF, S_TN, S_T1, S_T1);
            7'd58: r = mk(OP_MUL, S_T1, S_EPS, S_DABS);
            7'd59: r = mk(OP_SHLF, S_T2, S_TN, S_TN);
            7'd60: r = mk(OP_REJ_NLTS, S_T3, S_T1, S_T2);
            7'd61: r = mk(OP_DIV, S_TQ, S_T2, S_DABS);
            7'd62: r = mk(OP_REJ_LIM, S_T3, S_TQ, S_TQ);
            7'd63: r = mk(OP_MUL, S_T1, S_DX, S_TQ);
            7'd64: r = mk(OP_SARF, S_T1, S_T1, S_T1);
            7'd65: r = mk(OP_ADD, S_T1, S_OX, S_T1);
            7'd66: r = mk(OP_BESTX, S_T3, S_T1, S_T1);
            7'd67: r = mk(OP_MUL, S_T1, S_DY, S_TQ);
            7'd68: r = mk(OP_SARF, S_T1, S_T1, S_T1);
            7'd69: r = mk(OP_ADD, S_T1, S_OY, S_T1);
            7'd70: r = mk(OP_BESTY, S_T3, S_T1, S_T1);
            7'd71: r = mk(OP_MUL, S_T1, S_DZ, S_TQ);
            7'd72: r = mk(OP_SARF, S_T1, S_T1, S_T1);
            7'd73: r = mk(OP_ADD, S_T1, S_OZ, S_T1);
            7'd74: r = mk(OP_BESTZ, S_T3, S_T1, S_T1);
            7'd75: r = mk(OP_BESTD, S_T3, S_TQ, S_TQ);
            default: r = mk(OP_BESTD, S_T3, S_TQ, S_TQ);
        endcase
        return r;
    endfunction

endpackage

FILE: sv/nearest_ray_triangle_hit_core.sv
// Top level of the nearest ray/triangle hit core (Moller-Trumbore, fixed point).
// Depends on nrth_pkg, nrth_ctrl and nrth_dp.
//
//  channel   direction  handshake                     payload
//  --------  ---------  ----------------------------  -----------------------------
//  triangle  in         i_tri_valid / o_tri_ready     i_vert_*_x/y/z, i_last_triangle
//  hit       out        o_hit_valid / i_hit_ready     o_hit_found, o_hit_point_*,
//                                                     o_hit_distance
//  config    in         i_cfg_we (no wait)            i_cfg_idx, i_cfg_data
//
// One triangle at a time: a load phase fills the 16 scratch slots, then each
// microprogram step is read and executed; multiplies run on the shared 128x8
// multiplier, taking longer the wider |B| is, and t comes from the restoring divider;
// an early reject ends the program before its last step.
// Reset (synchronous, active low) restores the config defaults and clears the
// running best hit. A finished mesh result sits in the output register; the
// core takes the next triangle meanwhile and only stalls on the next last one.
module nearest_ray_triangle_hit_core #(
    parameter int COORD_WIDTH = nrth_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = nrth_pkg::FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [2:0]             i_cfg_idx,
    input  logic [31:0]            i_cfg_data,
    input  logic                   i_tri_valid,
    output logic                   o_tri_ready,
    input  logic [COORD_WIDTH-1:0] i_vert_a_x,
    input  logic [COORD_WIDTH-1:0] i_vert_a_y,
    input  logic [COORD_WIDTH-1:0] i_vert_a_z,
    input  logic [COORD_WIDTH-1:0] i_vert_b_x,
    input  logic [COORD_WIDTH-1:0] i_vert_b_y,
    input  logic [COORD_WIDTH-1:0] i_vert_b_z,
    input  logic [COORD_WIDTH-1:0] i_vert_c_x,
    input  logic [COORD_WIDTH-1:0] i_vert_c_y,
    input  logic [COORD_WIDTH-1:0] i_vert_c_z,
    input  logic                   i_last_triangle,
    output logic                   o_hit_valid,
    input  logic                   i_hit_ready,
    output logic                   o_hit_found,
    output logic [COORD_WIDTH-1:0] o_hit_point_x,
    output logic [COORD_WIDTH-1:0] o_hit_point_y,
    output logic [COORD_WIDTH-1:0] o_hit_point_z,
    output logic [nrth_pkg::DIST_W-1:0] o_hit_distance
);

    nrth_pkg::t_cmd    cmd;
    nrth_pkg::t_status status;

    // sequencer: accepts a triangle transfer only when idle
    nrth_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_tri_valid),
        .o_ready  (o_tri_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // arithmetic, best-hit state and the output register
    nrth_dp #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_va_x      (i_vert_a_x),
        .i_va_y      (i_vert_a_y),
        .i_va_z      (i_vert_a_z),
        .i_vb_x      (i_vert_b_x),
        .i_vb_y      (i_vert_b_y),
        .i_vb_z      (i_vert_b_z),
        .i_vc_x      (i_vert_c_x),
        .i_vc_y      (i_vert_c_y),
        .i_vc_z      (i_vert_c_z),
        .i_last      (i_last_triangle),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_valid     (o_hit_valid),
        .i_ready     (i_hit_ready),
        .o_hit_found (o_hit_found),
        .o_px        (o_hit_point_x),
        .o_py        (o_hit_point_y),
        .o_pz        (o_hit_point_z),
        .o_dist      (o_hit_distance)
    );

endmodule

FILE: sv/nrth_ctrl.sv
// Sequencer for the nearest-hit core: walks the microprogram in nrth_pkg.
// Depends on nrth_pkg; drives nrth_dp through t_cmd and reads t_status.
module nrth_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  nrth_pkg::t_status i_status,
    output nrth_pkg::t_cmd    o_cmd
);

    nrth_pkg::t_state r_state, n_state;
    logic [nrth_pkg::PCW-1:0] r_pc, n_pc;
    logic [3:0] r_cnt, n_cnt;
    nrth_pkg::t_instr ins;

    assign ins = nrth_pkg::prog(r_pc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nrth_pkg::ST_IDLE;
            r_pc    <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_pc           = r_pc;
        n_cnt          = r_cnt;
        o_ready        = 1'b0;
        o_cmd.capture  = 1'b0;
        o_cmd.load     = 1'b0;
        o_cmd.load_sel = r_cnt;
        o_cmd.exec     = 1'b0;
        o_cmd.op       = ins.op;
        o_cmd.dst      = ins.dst;
        o_cmd.ra       = ins.a;
        o_cmd.rb       = ins.b;
        o_cmd.emit     = 1'b0;
        case (r_state)
            nrth_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_cnt   = '0;
                    n_state = nrth_pkg::ST_LOAD;
                end
            end
            nrth_pkg::ST_LOAD: begin
                o_cmd.load = 1'b1;
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'(nrth_pkg::LOAD_CNT - 1)) begin
                    n_pc    = '0;
                    n_state = nrth_pkg::ST_READ;
                end
            end
            nrth_pkg::ST_READ: n_state = nrth_pkg::ST_EXEC;
            nrth_pkg::ST_EXEC: begin
                o_cmd.exec = 1'b1;
                if (nrth_pkg::is_multi(ins.op)) begin
                    n_state = nrth_pkg::ST_WAIT;
                end else if (i_status.reject || r_pc == nrth_pkg::PC_LAST) begin
                    n_state = nrth_pkg::ST_FINISH;
                end else begin
                    n_pc    = r_pc + 7'd1;
                    n_state = nrth_pkg::ST_READ;
                end
            end
            nrth_pkg::ST_WAIT: begin
                if (i_status.unit_done) begin
                    n_pc    = r_pc + 7'd1;
                    n_state = nrth_pkg::ST_READ;
                end
            end
            nrth_pkg::ST_FINISH: begin
                // if last, hold here until the output register is free
                if (!i_status.last) begin
                    n_state = nrth_pkg::ST_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = nrth_pkg::ST_IDLE;
                end
            end
            default: n_state = nrth_pkg::ST_IDLE;
        endcase
    end

`ifndef ASSERT_OFF
    a_load_exec_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.load && (o_cmd.exec || o_cmd.emit)))
        else $error("load overlaps execute or emit");
    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nrth_pkg::ST_IDLE && i_valid) |=> r_state == nrth_pkg::ST_LOAD)
        else $error("accepted triangle did not start loading");
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> (i_status.out_free && i_status.last))
        else $error("emit without free output or last flag");
    a_wait_multi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nrth_pkg::ST_WAIT) |-> nrth_pkg::is_multi(ins.op))
        else $error("waiting on a single-cycle op");
`endif

endmodule

FILE: sv/nrth_dp.sv
// Datapath for the nearest-hit core: scratch memory, ALU, sequential
// multiplier and divider, best-hit state, config and output registers. Uses nrth_pkg.
module nrth_dp #(
    parameter int COORD_WIDTH = nrth_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = nrth_pkg::FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [2:0]             i_cfg_idx,
    input  logic [31:0]            i_cfg_data,
    input  logic [COORD_WIDTH-1:0] i_va_x, i_va_y, i_va_z,
    input  logic [COORD_WIDTH-1:0] i_vb_x, i_vb_y, i_vb_z,
    input  logic [COORD_WIDTH-1:0] i_vc_x, i_vc_y, i_vc_z,
    input  logic                   i_last,
    input  nrth_pkg::t_cmd         i_cmd,
    output nrth_pkg::t_status      o_status,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic                   o_hit_found,
    output logic [COORD_WIDTH-1:0] o_px, o_py, o_pz,
    output logic [nrth_pkg::DIST_W-1:0] o_dist
);
    localparam int W  = nrth_pkg::W;
    localparam int CW = COORD_WIDTH;

    // configuration
    logic [31:0] r_ox, r_oy, r_oz;
    logic [17:0] r_dx, r_dy, r_dz;
    logic [16:0] r_eps;
    logic [30:0] r_maxd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ox <= '0; r_oy <= '0; r_oz <= '0;
            r_dx <= '0; r_dy <= '0; r_dz <= 18'd65536;
            r_eps <= 17'd1; r_maxd <= 31'd655353446;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                nrth_pkg::CFG_ORIGIN_X: r_ox <= i_cfg_data;
                nrth_pkg::CFG_ORIGIN_Y: r_oy <= i_cfg_data;
                nrth_pkg::CFG_ORIGIN_Z: r_oz <= i_cfg_data;
                nrth_pkg::CFG_DIR_X:    r_dx <= i_cfg_data[17:0];
                nrth_pkg::CFG_DIR_Y:    r_dy <= i_cfg_data[17:0];
                nrth_pkg::CFG_DIR_Z:    r_dz <= i_cfg_data[17:0];
                nrth_pkg::CFG_EPSILON:  r_eps <= i_cfg_data[16:0];
                nrth_pkg::CFG_MAX_DIST: r_maxd <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // captured triangle
    logic [CW-1:0] r_v [9];
    logic r_last;
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_v[0] <= i_va_x; r_v[1] <= i_va_y; r_v[2] <= i_va_z;
            r_v[3] <= i_vb_x; r_v[4] <= i_vb_y; r_v[5] <= i_vb_z;
            r_v[6] <= i_vc_x; r_v[7] <= i_vc_y; r_v[8] <= i_vc_z;
            r_last <= i_last;
        end
    end

    logic [W-1:0] load_val;
    always_comb begin
        case (i_cmd.load_sel)
            4'd9:  load_val = W'($signed(r_ox));
            4'd10: load_val = W'($signed(r_oy));
            4'd11: load_val = W'($signed(r_oz));
            4'd12: load_val = W'($signed(r_dx));
            4'd13: load_val = W'($signed(r_dy));
            4'd14: load_val = W'($signed(r_dz));
            4'd15: load_val = W'(r_eps);
            default: load_val = W'($signed(r_v[i_cmd.load_sel]));
        endcase
    end

    // scratch memory: one write, two registered reads
    logic [W-1:0] mem [2**nrth_pkg::AW];
    logic [W-1:0] r_rd_a, r_rd_b;
    logic                   we;
    logic [nrth_pkg::AW-1:0] waddr;
    logic [W-1:0]           wdata;

    always_ff @(posedge i_clk) begin
        if (we) mem[waddr] <= wdata;
        r_rd_a <= mem[i_cmd.ra];
        r_rd_b <= mem[i_cmd.rb];
    end

    // multiplier: 8 bits of the magnitude of B per cycle
    logic         r_mul_busy, r_mul_neg;
    logic [W-1:0] r_mul_a, r_mul_b, r_acc;
    logic [W-1:0] mul_sum, mul_res;
    logic         mul_done;
    assign mul_sum  = r_acc + r_mul_a * W'(r_mul_b[7:0]);
    assign mul_done = r_mul_busy && (r_mul_b[W-1:8] == '0);
    assign mul_res  = r_mul_neg ? -mul_sum : mul_sum;

    // divider: restoring, one quotient bit per cycle
    logic         r_div_busy;
    logic [6:0]   r_div_cnt;
    logic [W-1:0] r_div_n, r_div_d, r_rem, r_quo;
    logic [W:0]   div_rs, div_diff;
    logic         div_ge, div_done;
    assign div_rs   = {r_rem, r_div_n[W-1]};
    assign div_diff = div_rs - {1'b0, r_div_d};
    assign div_ge   = !div_diff[W];
    assign div_done = r_div_busy && (r_div_cnt == '0);

    logic mul_start, div_start;
    assign mul_start = i_cmd.exec && (i_cmd.op == nrth_pkg::OP_MUL);
    assign div_start = i_cmd.exec && (i_cmd.op == nrth_pkg::OP_DIV);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_busy <= 1'b0;
            r_div_busy <= 1'b0;
        end else begin
            if (mul_start) r_mul_busy <= 1'b1;
            else if (mul_done) r_mul_busy <= 1'b0;
            if (div_start) r_div_busy <= 1'b1;
            else if (div_done) r_div_busy <= 1'b0;
        end
        if (mul_start) begin
            r_mul_a   <= r_rd_a;
            r_mul_b   <= r_rd_b[W-1] ? -r_rd_b : r_rd_b;
            r_mul_neg <= r_rd_b[W-1];
            r_acc     <= '0;
        end else if (r_mul_busy) begin
            r_acc   <= mul_sum;
            r_mul_a <= r_mul_a << 8;
            r_mul_b <= r_mul_b >> 8;
        end
        if (div_start) begin
            r_div_n   <= r_rd_a;
            r_div_d   <= r_rd_b;
            r_rem     <= '0;
            r_quo     <= '0;
            r_div_cnt <= 7'(W - 1);
        end else if (r_div_busy) begin
            r_rem     <= div_ge ? div_diff[W-1:0] : div_rs[W-1:0];
            r_quo     <= {r_quo[W-2:0], div_ge};
            r_div_n   <= r_div_n << 1;
            r_div_cnt <= r_div_cnt - 7'd1;
        end
    end

    // combinational ALU and checks
    logic         r_neg, r_best_valid;
    logic [30:0]  r_best_d;
    logic [CW-1:0] r_bx, r_by, r_bz;
    logic [W-1:0] alu;
    logic         alu_we, rej;
    logic [30:0]  limit;
    assign limit = r_best_valid ? r_best_d : r_maxd;

    always_comb begin
        alu    = '0;
        alu_we = 1'b0;
        rej    = 1'b0;
        case (i_cmd.op)
            nrth_pkg::OP_SUB:   begin alu = r_rd_a - r_rd_b; alu_we = 1'b1; end
            nrth_pkg::OP_ADD:   begin alu = r_rd_a + r_rd_b; alu_we = 1'b1; end
            nrth_pkg::OP_ABS:   begin
                alu = r_rd_a[W-1] ? -r_rd_a : r_rd_a; alu_we = 1'b1;
            end
            nrth_pkg::OP_NEGIF: begin alu = r_neg ? -r_rd_a : r_rd_a; alu_we = 1'b1; end
            nrth_pkg::OP_SHL2F: begin alu = r_rd_a << (2 * FRAC_BITS); alu_we = 1'b1; end
            nrth_pkg::OP_SHLF:  begin alu = r_rd_a << FRAC_BITS; alu_we = 1'b1; end
            nrth_pkg::OP_SARF:  begin
                alu = W'($signed(r_rd_a) >>> FRAC_BITS); alu_we = 1'b1;
            end
            nrth_pkg::OP_REJ_ZLTU: rej = (r_rd_a == '0) || (r_rd_a < r_rd_b);
            nrth_pkg::OP_REJ_NEG:  rej = r_rd_a[W-1];
            nrth_pkg::OP_REJ_LTS:  rej = $signed(r_rd_a) < $signed(r_rd_b);
            nrth_pkg::OP_REJ_NLTS: rej = !($signed(r_rd_a) < $signed(r_rd_b));
            nrth_pkg::OP_REJ_LIM:
                rej = (r_rd_a[W-1:64] != '0) || (r_rd_a[63:0] >= 64'(limit));
            default: ;
        endcase
    end

    always_comb begin
        we    = 1'b0;
        waddr = i_cmd.dst;
        wdata = alu;
        if (i_cmd.load) begin
            we = 1'b1; waddr = nrth_pkg::AW'(i_cmd.load_sel); wdata = load_val;
        end else if (mul_done) begin
            we = 1'b1; wdata = mul_res;
        end else if (div_done) begin
            we = 1'b1; wdata = {r_quo[W-2:0], div_ge};
        end else if (i_cmd.exec && alu_we) begin
            we = 1'b1;
        end
    end

    function automatic logic [CW-1:0] sat(input logic [W-1:0] v);
        logic ovf;
        ovf = !((&v[W-1:CW-1]) || !(|v[W-1:CW-1]));
        if (!ovf) return v[CW-1:0];
        return v[W-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    endfunction

    // best-hit state and output register
    logic r_out_valid;
    assign o_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                r_best_valid <= 1'b0;
                r_out_valid  <= 1'b1;
            end else begin
                if (i_cmd.exec && i_cmd.op == nrth_pkg::OP_BESTD) r_best_valid <= 1'b1;
                if (r_out_valid && i_ready) r_out_valid <= 1'b0;
            end
        end
        if (i_cmd.exec) begin
            case (i_cmd.op)
                nrth_pkg::OP_ABS:   r_neg <= r_rd_a[W-1];
                nrth_pkg::OP_BESTX: r_bx <= sat(r_rd_a);
                nrth_pkg::OP_BESTY: r_by <= sat(r_rd_a);
                nrth_pkg::OP_BESTZ: r_bz <= sat(r_rd_a);
                nrth_pkg::OP_BESTD: r_best_d <= r_rd_a[30:0];
                default: ;
            endcase
        end
        if (i_cmd.emit) begin
            o_hit_found <= r_best_valid;
            o_px   <= r_best_valid ? r_bx : '0;
            o_py   <= r_best_valid ? r_by : '0;
            o_pz   <= r_best_valid ? r_bz : '0;
            o_dist <= r_best_valid ? r_best_d : '0;
        end
    end

    assign o_status.reject    = i_cmd.exec && rej;
    assign o_status.unit_done = mul_done || div_done;
    assign o_status.last      = r_last;
    assign o_status.out_free  = !r_out_valid || i_ready;

`ifndef ASSERT_OFF
    a_units_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_mul_busy && r_div_busy))
        else $error("multiplier and divider busy together");
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> (r_rd_b != '0))
        else $error("divide by zero started");
    a_no_write_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mul_done || div_done) |-> !i_cmd.load)
        else $error("unit result collides with load");
`endif

endmodule
